[rtl/accumulator_alu_with_flags_top_defines.svh]
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// same-cycle implication
`define ALUF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALUF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/aluf_pkg.sv]
`timescale 1ns / 1ps

package aluf_pkg;

	localparam int FLAG_Z_BIT = 7;
	localparam int FLAG_N_BIT = 6;
	localparam int FLAG_H_BIT = 5;
	localparam int FLAG_C_BIT = 4;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_ADC  = 4'd1,
		OP_SUB  = 4'd2,
		OP_SBC  = 4'd3,
		OP_AND  = 4'd4,
		OP_XOR  = 4'd5,
		OP_OR   = 4'd6,
		OP_CP   = 4'd7,
		OP_INC  = 4'd8,
		OP_DEC  = 4'd9,
		OP_RLCA = 4'd10,
		OP_RRCA = 4'd11,
		OP_RRA  = 4'd12,
		OP_CPL  = 4'd13,
		OP_CCF  = 4'd14
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] a_value;
		logic [7:0] operand;
		logic [7:0] flags_in;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] flags_out;
	} rsp_t;

endpackage

[rtl/aluf_core.sv]
`timescale 1ns / 1ps

module aluf_core (
	input  aluf_pkg::cmd_t cmd,
	output aluf_pkg::rsp_t rsp
);

	logic       cin;
	logic [8:0] add_full;
	logic [4:0] add_half;
	logic [8:0] sub_full;
	logic [4:0] sub_half;
	logic [7:0] res;
	logic       z_fl;
	logic       n_fl;
	logic       h_fl;
	logic       c_fl;
	logic       use_cin;
	logic       fz_in;
	logic       fc_in;

	assign fz_in   = cmd.flags_in[aluf_pkg::FLAG_Z_BIT];
	assign fc_in   = cmd.flags_in[aluf_pkg::FLAG_C_BIT];
	assign use_cin = (cmd.op == aluf_pkg::OP_ADC) || (cmd.op == aluf_pkg::OP_SBC);
	assign cin     = use_cin & fc_in;

	assign add_full = {1'b0, cmd.a_value} + {1'b0, cmd.operand} + {8'd0, cin};
	assign add_half = {1'b0, cmd.a_value[3:0]} + {1'b0, cmd.operand[3:0]} + {4'd0, cin};
	assign sub_full = {1'b0, cmd.a_value} - {1'b0, cmd.operand} - {8'd0, cin};
	assign sub_half = {1'b0, cmd.a_value[3:0]} - {1'b0, cmd.operand[3:0]} - {4'd0, cin};

	always_comb begin
		res  = cmd.a_value;
		z_fl = fz_in;
		n_fl = cmd.flags_in[aluf_pkg::FLAG_N_BIT];
		h_fl = cmd.flags_in[aluf_pkg::FLAG_H_BIT];
		c_fl = fc_in;
		case (cmd.op)
			aluf_pkg::OP_ADD, aluf_pkg::OP_ADC: begin
				res  = add_full[7:0];
				z_fl = (add_full[7:0] == 8'd0);
				n_fl = 1'b0;
				h_fl = add_half[4];
				c_fl = add_full[8];
			end
			aluf_pkg::OP_SUB, aluf_pkg::OP_SBC, aluf_pkg::OP_CP: begin
				if (cmd.op != aluf_pkg::OP_CP) begin
					res = sub_full[7:0];
				end
				z_fl = (sub_full[7:0] == 8'd0);
				n_fl = 1'b1;
				h_fl = sub_half[4];
				c_fl = sub_full[8];
			end
			aluf_pkg::OP_AND: begin
				res  = cmd.a_value & cmd.operand;
				z_fl = ((cmd.a_value & cmd.operand) == 8'd0);
				n_fl = 1'b0;
				h_fl = 1'b1;
				c_fl = 1'b0;
			end
			aluf_pkg::OP_XOR: begin
				res  = cmd.a_value ^ cmd.operand;
				z_fl = ((cmd.a_value ^ cmd.operand) == 8'd0);
				n_fl = 1'b0;
				h_fl = 1'b0;
				c_fl = 1'b0;
			end
			aluf_pkg::OP_OR: begin
				res  = cmd.a_value | cmd.operand;
				z_fl = ((cmd.a_value | cmd.operand) == 8'd0);
				n_fl = 1'b0;
				h_fl = 1'b0;
				c_fl = 1'b0;
			end
			aluf_pkg::OP_INC: begin
				res  = cmd.a_value + 8'd1;
				z_fl = (cmd.a_value == 8'hff);
				n_fl = 1'b0;
				h_fl = (cmd.a_value[3:0] == 4'hf);
			end
			aluf_pkg::OP_DEC: begin
				res  = cmd.a_value - 8'd1;
				z_fl = (cmd.a_value == 8'd1);
				n_fl = 1'b1;
				h_fl = (cmd.a_value[3:0] == 4'h0);
			end
			aluf_pkg::OP_RLCA: begin
				res  = {cmd.a_value[6:0], cmd.a_value[7]};
				z_fl = 1'b0;
				n_fl = 1'b0;
				h_fl = 1'b0;
				c_fl = cmd.a_value[7];
			end
			aluf_pkg::OP_RRCA: begin
				res  = {cmd.a_value[0], cmd.a_value[7:1]};
				z_fl = 1'b0;
				n_fl = 1'b0;
				h_fl = 1'b0;
				c_fl = cmd.a_value[0];
			end
			aluf_pkg::OP_RRA: begin
				res  = {fc_in, cmd.a_value[7:1]};
				z_fl = 1'b0;
				n_fl = 1'b0;
				h_fl = 1'b0;
				c_fl = cmd.a_value[0];
			end
			aluf_pkg::OP_CPL: begin
				res  = ~cmd.a_value;
				n_fl = 1'b1;
				h_fl = 1'b1;
			end
			aluf_pkg::OP_CCF: begin
				n_fl = 1'b0;
				h_fl = 1'b0;
				c_fl = ~fc_in;
			end
			default: begin
				res = cmd.a_value;
			end
		endcase
	end

	assign rsp.result    = res;
	assign rsp.flags_out = {z_fl, n_fl, h_fl, c_fl, 4'b0000};

endmodule

[rtl/accumulator_alu_with_flags_top.sv]
`timescale 1ns / 1ps
// Eight-bit accumulator ALU with Z/N/H/C flags.
// Command channel: drive cmd (op, a_value, operand, flags_in) and pulse start;
// a beat is taken at each rising edge with start high and busy low. busy is
// always low, so a new beat may be issued every cycle.
// Result channel: done is high for exactly one cycle with rsp (result,
// flags_out) valid in that cycle; the receiver must take it then and
// cannot hold it off.
// Pipeline: an accepted beat goes into an input register, then through one
// combinational ALU pass into a result register. Throughput: one beat
// per cycle, in order.
// Reset (arst_n low, asynchronous) drops any beat in flight and clears done;
// no state survives between beats.
// flags_out always has its low nibble zero; the low nibble of flags_in
// is ignored.

`include "accumulator_alu_with_flags_top_defines.svh"

module accumulator_alu_with_flags_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  aluf_pkg::cmd_t cmd,
	output logic           done,
	output aluf_pkg::rsp_t rsp
);

	logic           valid_s1;
	aluf_pkg::cmd_t cmd_s1;
	aluf_pkg::rsp_t rsp_comb;
	logic           done_s2;
	aluf_pkg::rsp_t rsp_s2;
	logic           accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	aluf_core u_core (
		.cmd (cmd_s1),
		.rsp (rsp_comb)
	);

	assign done = done_s2;
	assign rsp  = rsp_s2;

	`ALUF_ASSERT_NEXT(a_accept_loads, clk, arst_n, accept, valid_s1, "accepted beat not staged")
	`ALUF_ASSERT_NEXT(a_stage_to_done, clk, arst_n, valid_s1, done_s2, "staged beat lost")
	`ALUF_ASSERT_NEXT(a_no_spurious, clk, arst_n, !valid_s1, !done_s2, "result without beat")
	`ALUF_ASSERT_SAME(a_low_nibble, clk, arst_n, done_s2, rsp_s2.flags_out[3:0] == 4'd0, "flag low nibble set")
	`ALUF_ASSERT_NEXT(a_cp_keeps_a, clk, arst_n, valid_s1 && (cmd_s1.op == aluf_pkg::OP_CP), rsp_s2.result == $past(cmd_s1.a_value), "CP changed A")

endmodule
